// File: hw/rtl/assert_macros.svh
// assertion helpers, clocked on clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/asln_pkg.sv
package asln_pkg;

  localparam int WIDE_W = 128;
  localparam int Q_W    = 41;

  localparam logic [Q_W-1:0]    STEP_CAP = 41'h100_0000_0000;
  localparam logic [WIDE_W-1:0] SMALL_D2 = 128'd3;
  localparam logic [WIDE_W-1:0] SMALL_D3 = 128'd184468;

  localparam logic [1:0] REG_DIM   = 2'd0;
  localparam logic [1:0] REG_ETA   = 2'd1;
  localparam logic [1:0] REG_TOL   = 2'd2;
  localparam logic [1:0] REG_PASS  = 2'd3;

  typedef logic [WIDE_W-1:0] wide_t;
  typedef logic [Q_W-1:0]    step_t;

endpackage

// File: hw/rtl/adaptive_smoothing_length_newton.sv
// Newton update of the particle smoothing length, one particle at a time.
// Input words arrive on in_*: tdata holds current_h, density, density_slope
// and particle_mass (Q16.16), tlast marks the last particle of a pass.
// Result words leave on out_*: new_h and the pass maximum change in tdata,
// flags in tuser, pass end on tlast. The user writes registers on cfg_* only
// while the block is idle; the block itself does not enforce this. cfg_ready is always high.
// A new word is taken once the previous result is in the output register.
// The work is done by the bit-serial 128x32 multiplier (six products in
// 2-D, nine in 3-D), the 144-step restoring divider for the Newton step
// and the 56-step divider for the change.
// Reset restores the register defaults and clears the pass maximum and the
// pass counter. When the receiver stalls the result waits in the output
// register; the block accepts one more word and holds its finished result
// until the output register frees up.
`include "assert_macros.svh"

module adaptive_smoothing_length_newton (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // current_h, density, density_slope, particle_mass
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // new_h, pass_max_change
  output logic [2:0]   out_tuser,  // h_updated, converged, stop_iteration
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import asln_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MGO   = 4'd1;
  localparam logic [3:0] S_MWAIT = 4'd2;
  localparam logic [3:0] S_PREP  = 4'd3;
  localparam logic [3:0] S_DGO   = 4'd4;
  localparam logic [3:0] S_DWAIT = 4'd5;
  localparam logic [3:0] S_STEP  = 4'd6;
  localparam logic [3:0] S_CHG   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  localparam logic [3:0] OP_RH   = 4'd0;
  localparam logic [3:0] OP_RHH  = 4'd1;
  localparam logic [3:0] OP_RHHH = 4'd2;
  localparam logic [3:0] OP_ME   = 4'd3;
  localparam logic [3:0] OP_MEE  = 4'd4;
  localparam logic [3:0] OP_MEEE = 4'd5;
  localparam logic [3:0] OP_SH   = 4'd6;
  localparam logic [3:0] OP_SHH  = 4'd7;
  localparam logic [3:0] OP_SHHH = 4'd8;

  localparam int CHG_STEPS = 56;

  // configuration
  logic        dim_r;
  logic [31:0] eta_r, tol_r;
  logic [15:0] maxp_r;

  // pass state
  logic [31:0] rmax_r;
  logic [15:0] pcnt_r;

  logic [3:0]  state_r;
  logic [3:0]  op_r;

  logic [31:0] h_r, rho_r, slope_r, mass_r;
  logic        last_r;
  wide_t       ta_r, tb_r, tp_r, rh_r, rhh_r;
  wide_t       fmag_r, dmag_r;
  logic        fneg_r, dneg_r;
  logic        ok_r;
  logic [31:0] hn_r;

  logic [55:0] cdvd_r;
  logic [32:0] crem_r;
  logic [31:0] cq_r;
  logic        csat_r;
  logic [5:0]  ccnt_r;

  logic        out_valid_r;
  logic [31:0] out_h_r, out_max_r;
  logic        out_upd_r, out_end_r, out_conv_r, out_stop_r;

  // arithmetic units
  logic        mul_start, mul_done;
  wide_t       mul_a, mul_p;
  logic [31:0] mul_b;
  logic        div_start, div_done;
  step_t       div_q;

  asln_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_a),
    .mplier (mul_b),
    .done   (mul_done),
    .prod   (mul_p)
  );

  asln_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (fmag_r),
    .den   (dmag_r),
    .done  (div_done),
    .quot  (div_q)
  );

  logic [31:0] smag;
  logic [3:0]  op_next;
  logic        op_last;

  assign smag = slope_r[31] ? (32'd0 - slope_r) : slope_r;

  always_comb begin
    case (op_r)
      OP_RH:   begin mul_a = {96'd0, rho_r};  mul_b = h_r;   end
      OP_RHH:  begin mul_a = ta_r;            mul_b = h_r;   end
      OP_RHHH: begin mul_a = ta_r;            mul_b = h_r;   end
      OP_ME:   begin mul_a = {96'd0, mass_r}; mul_b = eta_r; end
      OP_MEE:  begin mul_a = tb_r;            mul_b = eta_r; end
      OP_MEEE: begin mul_a = tb_r;            mul_b = eta_r; end
      OP_SH:   begin mul_a = {96'd0, smag};   mul_b = h_r;   end
      OP_SHH:  begin mul_a = tp_r;            mul_b = h_r;   end
      OP_SHHH: begin mul_a = tp_r;            mul_b = h_r;   end
      default: begin mul_a = '0;              mul_b = '0;    end
    endcase
    if (!dim_r && (op_r == OP_RHH || op_r == OP_MEE)) begin
      op_next = op_r + 4'd2;
    end else begin
      op_next = op_r + 4'd1;
    end
    op_last = dim_r ? (op_r == OP_SHHH) : (op_r == OP_SHH);
  end

  assign mul_start = (state_r == S_MGO);
  assign div_start = (state_r == S_DGO) && (dmag_r >= (dim_r ? SMALL_D3 : SMALL_D2));

  // numerator and derivative magnitudes
  wide_t tq;
  logic  fneg_c, dneg_c;
  wide_t fmag_c, dmag_c;

  always_comb begin
    tq     = dim_r ? ((rhh_r << 17) + (rhh_r << 16)) : (rh_r << 17);
    fneg_c = ta_r < tb_r;
    fmag_c = fneg_c ? (tb_r - ta_r) : (ta_r - tb_r);
    if (!slope_r[31]) begin
      dmag_c = tp_r + tq;
      dneg_c = 1'b0;
    end else if (tq >= tp_r) begin
      dmag_c = tq - tp_r;
      dneg_c = 1'b0;
    end else begin
      dmag_c = tp_r - tq;
      dneg_c = 1'b1;
    end
  end

  // applying the step
  logic [41:0] hsum;
  logic        step_ok;
  logic [31:0] step_h;

  always_comb begin
    hsum = {10'd0, h_r} + {1'b0, div_q};
    if (fneg_r == dneg_r) begin
      step_ok = div_q < {9'd0, h_r};
      step_h  = h_r - div_q[31:0];
    end else begin
      step_ok = hsum <= 42'h0_FFFF_FFFF;
      step_h  = hsum[31:0];
    end
    step_ok = step_ok && (h_r != 32'd0);
  end

  // change division, one quotient bit per cycle
  logic [32:0] crem_sh, crem_nxt;
  logic        cbit;

  always_comb begin
    crem_sh  = {crem_r[31:0], cdvd_r[55]};
    cbit     = crem_sh >= {1'b0, h_r};
    crem_nxt = cbit ? (crem_sh - {1'b0, h_r}) : crem_sh;
  end

  // pass bookkeeping
  logic [31:0] chg;
  logic [31:0] rmax_new;
  logic [15:0] pcnt_inc;
  logic        conv_c, stop_c;
  logic        out_load;

  always_comb begin
    chg      = csat_r ? 32'hFFFF_FFFF : cq_r;
    rmax_new = (ok_r && chg > rmax_r) ? chg : rmax_r;
    pcnt_inc = (pcnt_r == 16'hFFFF) ? pcnt_r : pcnt_r + 16'd1;
    conv_c   = rmax_new < tol_r;
    stop_c   = conv_c || (pcnt_inc >= maxp_r);
    out_load = (state_r == S_FIN) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r       <= 1'b0;
      eta_r       <= 32'd78643;
      tol_r       <= 32'd17;
      maxp_r      <= 16'd50;
      rmax_r      <= '0;
      pcnt_r      <= '0;
      state_r     <= S_IDLE;
      op_r        <= OP_RH;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_DIM:  dim_r  <= cfg_data[0];
          REG_ETA:  eta_r  <= cfg_data;
          REG_TOL:  tol_r  <= cfg_data;
          REG_PASS: maxp_r <= cfg_data[15:0];
          default:  dim_r  <= dim_r;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= OP_RH;
            state_r <= S_MGO;
          end
        end
        S_MGO: begin
          state_r <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mul_done) begin
            op_r    <= op_next;
            state_r <= op_last ? S_PREP : S_MGO;
          end
        end
        S_PREP: begin
          state_r <= S_DGO;
        end
        S_DGO: begin
          state_r <= div_start ? S_DWAIT : S_FIN;
        end
        S_DWAIT: begin
          if (div_done) begin
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          state_r <= step_ok ? S_CHG : S_FIN;
        end
        S_CHG: begin
          if (ccnt_r == 6'(CHG_STEPS - 1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            state_r <= S_IDLE;
            if (last_r) begin
              rmax_r <= '0;
              pcnt_r <= stop_c ? 16'd0 : pcnt_inc;
            end else begin
              rmax_r <= rmax_new;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      h_r     <= in_tdata[31:0];
      rho_r   <= in_tdata[63:32];
      slope_r <= in_tdata[95:64];
      mass_r  <= in_tdata[127:96];
      last_r  <= in_tlast;
    end
    if (state_r == S_MWAIT && mul_done) begin
      case (op_r)
        OP_RH:   begin ta_r <= mul_p; rh_r <= mul_p;  end
        OP_RHH:  begin ta_r <= mul_p; rhh_r <= mul_p; end
        OP_RHHH: ta_r <= mul_p;
        OP_ME:   tb_r <= mul_p;
        OP_MEE:  tb_r <= mul_p;
        OP_MEEE: tb_r <= mul_p;
        default: tp_r <= mul_p;
      endcase
    end
    if (state_r == S_PREP) begin
      fmag_r <= fmag_c;
      dmag_r <= dmag_c;
      fneg_r <= fneg_c;
      dneg_r <= dneg_c;
      ok_r   <= 1'b0;
      hn_r   <= h_r;
    end
    if (state_r == S_STEP && step_ok) begin
      ok_r   <= 1'b1;
      hn_r   <= step_h;
      cdvd_r <= {div_q[31:0], 24'd0};
      crem_r <= '0;
      cq_r   <= '0;
      csat_r <= 1'b0;
      ccnt_r <= '0;
    end
    if (state_r == S_CHG) begin
      cdvd_r <= {cdvd_r[54:0], 1'b0};
      crem_r <= crem_nxt;
      cq_r   <= {cq_r[30:0], cbit};
      csat_r <= csat_r | cq_r[31];
      ccnt_r <= ccnt_r + 6'd1;
    end
    if (out_load) begin
      out_h_r    <= hn_r;
      out_upd_r  <= ok_r;
      out_end_r  <= last_r;
      out_max_r  <= last_r ? rmax_new : 32'd0;
      out_conv_r <= last_r && conv_c;
      out_stop_r <= last_r && stop_c;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_max_r, out_h_r};
  assign out_tuser  = {out_stop_r, out_conv_r, out_upd_r};
  assign out_tlast  = out_end_r;

  `ASSERT_IMPL(a_upd_nonzero, out_valid_r && out_upd_r, out_h_r != 32'd0, "accepted step gave zero length")
  `ASSERT_IMPL(a_mid_pass_quiet, out_valid_r && !out_end_r, out_max_r == 32'd0 && !out_conv_r && !out_stop_r, "pass report outside pass end")
  `ASSERT_IMPL(a_conv_stops, out_valid_r && out_conv_r, out_stop_r, "converged without stop")
  `ASSERT_NEXT(a_stop_clears, out_load && last_r && stop_c, pcnt_r == 16'd0 && rmax_r == 32'd0, "pass state not cleared after stop")

endmodule

// File: hw/rtl/asln_mul.sv
module asln_mul (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  asln_pkg::wide_t  mcand,
  input  logic [31:0]      mplier,
  output logic             done,
  output asln_pkg::wide_t  prod
);
  import asln_pkg::*;

  wide_t       acc_r, acc_nxt;
  wide_t       a_r;
  logic [31:0] b_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  // one multiplier bit per cycle, lsb first
  always_comb begin
    acc_nxt = acc_r;
    if (b_r[0]) begin
      acc_nxt = acc_r + a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= mcand;
      b_r   <= mplier;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      a_r   <= {a_r[WIDE_W-2:0], 1'b0};
      b_r   <= {1'b0, b_r[31:1]};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// File: hw/rtl/asln_div.sv
module asln_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  asln_pkg::wide_t  num,
  input  asln_pkg::wide_t  den,
  output logic             done,
  output asln_pkg::step_t  quot
);
  import asln_pkg::*;

  localparam int STEPS = WIDE_W + 16;

  wide_t       rem_r, num_r, den_r;
  step_t       q_r;
  logic [7:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  wide_t       rem_sh, rem_nxt;
  logic        qbit;
  logic [Q_W:0] q_sh;
  step_t       q_nxt;

  // restoring division, numerator followed by 16 zero bits
  always_comb begin
    rem_sh  = {rem_r[WIDE_W-2:0], num_r[WIDE_W-1]};
    qbit    = rem_r[WIDE_W-1] || (rem_sh >= den_r);
    rem_nxt = qbit ? (rem_sh - den_r) : rem_sh;
    q_sh    = {q_r, qbit};
    if (q_r >= STEP_CAP) begin
      q_nxt = STEP_CAP;
    end else if (q_sh > {1'b0, STEP_CAP}) begin
      q_nxt = STEP_CAP;
    end else begin
      q_nxt = q_sh[Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 8'd1;
        if (cnt_r == 8'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      num_r <= num;
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[WIDE_W-2:0], 1'b0};
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// File: test/adaptive_smoothing_length_newton_tb.sv
module adaptive_smoothing_length_newton_tb;
  import asln_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [31:0] h;
    logic [31:0] density;
    logic [31:0] slope;
    logic [31:0] mass;
    logic        last;
  } particle_t;

  typedef struct {
    logic [31:0] new_h;
    logic        h_updated;
    logic        pass_end;
    logic [31:0] peak_chg;
    logic        converged;
    logic        stop;
  } h_update_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // current_h, density, density_slope, particle_mass
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;  // new_h, pass_max_change
  logic [2:0]   out_tuser;  // h_updated, converged, stop_iteration
  logic         out_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;

  // shadow registers and state
  logic        dim3;
  logic [31:0] eta;
  logic [31:0] tol;
  logic [15:0] pass_limit;
  logic [31:0] pass_peak_change;
  logic [15:0] pass_count;

  h_update_t   pending_updates[$];
  int          errors;
  int          idle_cycles;
  bit          calm;
  int          hold_req;
  int          hold_left;

  adaptive_smoothing_length_newton dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic h_update_t newton_update(particle_t p);
    logic [127:0] ta, tb, tp, tq, fmag, dmag, small_lim;
    logic [143:0] quo;
    logic [63:0]  q, hv, hn, diff, chg;
    logic [31:0]  smag;
    logic         sneg, fneg, dneg, ok;
    h_update_t    r;
    hv   = {32'd0, p.h};
    sneg = p.slope[31];
    smag = sneg ? -p.slope : p.slope;
    if (!dim3) begin
      ta = 128'(p.density) * p.h * p.h;
      tb = 128'(eta) * eta * p.mass;
      tp = 128'(smag) * p.h * p.h;
      tq = (128'(p.density) * p.h) << 17;
      small_lim = SMALL_D2;
    end else begin
      ta = 128'(p.density) * p.h * p.h * p.h;
      tb = 128'(eta) * eta * eta * p.mass;
      tp = 128'(smag) * p.h * p.h * p.h;
      tq = (128'(p.density) * p.h * 3 * p.h) << 16;
      small_lim = SMALL_D3;
    end
    fneg = ta < tb;
    fmag = fneg ? tb - ta : ta - tb;
    if (!sneg) begin
      dmag = tp + tq;
      dneg = 1'b0;
    end else if (tq >= tp) begin
      dmag = tq - tp;
      dneg = 1'b0;
    end else begin
      dmag = tp - tq;
      dneg = 1'b1;
    end
    ok = 1'b0;
    hn = hv;
    if (dmag >= small_lim) begin
      quo = {fmag, 16'd0} / 144'(dmag);
      q = (quo >= 144'(STEP_CAP)) ? 64'(STEP_CAP) : quo[63:0];
      if (fneg == dneg) begin
        if (q < hv) begin
          hn = hv - q;
          ok = 1'b1;
        end
      end else if (hv + q <= 64'hFFFF_FFFF) begin
        hn = hv + q;
        ok = 1'b1;
      end
    end
    if (ok && hv != 0) begin
      diff = (hn >= hv) ? hn - hv : hv - hn;
      chg = (diff << 24) / hv;
      if (chg > 64'hFFFF_FFFF) chg = 64'hFFFF_FFFF;
      if (chg[31:0] > pass_peak_change) pass_peak_change = chg[31:0];
    end else begin
      ok = 1'b0;
      hn = hv;
    end
    r.new_h = hn[31:0];
    r.h_updated = ok;
    r.pass_end = p.last;
    r.peak_chg = '0;
    r.converged = 1'b0;
    r.stop = 1'b0;
    if (p.last) begin
      if (pass_count != 16'hFFFF) pass_count = pass_count + 1;
      r.peak_chg = pass_peak_change;
      r.converged = pass_peak_change < tol;
      r.stop = r.converged || pass_count >= pass_limit;
      pass_peak_change = '0;
      if (r.stop) pass_count = '0;
    end
    return r;
  endfunction

  // result checker and watchdog, sampled mid-cycle
  always @(negedge clk) begin
    h_update_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_tdata);
        errors++;
      end else begin
        e = pending_updates.pop_front();
        if (out_tdata[31:0] !== e.new_h) begin
          $display("%0t: new_h exp %h got %h", $time, e.new_h, out_tdata[31:0]);
          errors++;
        end
        if (out_tuser[0] !== e.h_updated) begin
          $display("%0t: h_updated exp %b got %b", $time, e.h_updated, out_tuser[0]);
          errors++;
        end
        if (out_tlast !== e.pass_end) begin
          $display("%0t: pass_end exp %b got %b", $time, e.pass_end, out_tlast);
          errors++;
        end
        if (out_tdata[63:32] !== e.peak_chg) begin
          $display("%0t: peak change exp %h got %h", $time, e.peak_chg,
                   out_tdata[63:32]);
          errors++;
        end
        if (out_tuser[1] !== e.converged) begin
          $display("%0t: converged exp %b got %b", $time, e.converged, out_tuser[1]);
          errors++;
        end
        if (out_tuser[2] !== e.stop) begin
          $display("%0t: stop exp %b got %b", $time, e.stop, out_tuser[2]);
          errors++;
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left <= hold_req;
      hold_req = 0;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 20);
    end
  end

  task automatic send_particle(particle_t p);
    if (!calm && $urandom_range(99) < 20) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 20);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p.mass, p.slope, p.density, p.h};
    in_tlast  <= p.last;
    forever begin
      @(negedge clk);
      if (in_tready) break;
      @(posedge clk);
    end
    @(posedge clk);
    pending_updates.push_back(newton_update(p));
  endtask

  task automatic send_fields(logic [31:0] h, logic [31:0] r, logic [31:0] s,
                             logic [31:0] m, logic last);
    particle_t p;
    p.h = h;
    p.density = r;
    p.slope = s;
    p.mass = m;
    p.last = last;
    send_particle(p);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    case (idx)
      REG_DIM:  dim3 = val[0];
      REG_ETA:  eta = val;
      REG_TOL:  tol = val;
      REG_PASS: pass_limit = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic d, logic [31:0] e, logic [31:0] t, logic [15:0] n);
    write_reg(REG_DIM, {31'd0, d});
    write_reg(REG_ETA, e);
    write_reg(REG_TOL, t);
    write_reg(REG_PASS, {16'd0, n});
    cfg_valid <= 1'b0;
  endtask

  function automatic particle_t random_particle();
    particle_t p;
    int mode;
    mode = $urandom_range(9);
    if (mode < 3) begin
      p.h = $urandom;
      p.density = $urandom;
      p.slope = $urandom;
      p.mass = $urandom;
    end else begin
      // plausible particles near equilibrium
      p.h = $urandom_range(32'h0010_0000, 32'h0000_2000);
      p.density = $urandom_range(32'h0040_0000, 32'h0000_4000);
      p.mass = p.density + $urandom_range(32'h0000_8000) - 32'h0000_4000;
      p.slope = -($urandom_range(32'h0100_0000));
      if (mode == 9) p.slope = $urandom_range(32'h0001_0000);
    end
    p.last = ($urandom_range(5) == 0);
    return p;
  endfunction

  task automatic reset_block;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    out_tready = 1'b0;
    dim3 = 1'b0;
    eta = 32'd78643;
    tol = 32'd17;
    pass_limit = 16'd50;
    pass_peak_change = '0;
    pass_count = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  task automatic test_defaults_directed;
    send_fields(32'h0001_0000, 32'h0001_0000, 32'h0000_1000, 32'h0001_0000, 1'b0);
    send_fields(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
    send_fields(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0);
    send_fields(32'h0000_0001, 32'h0000_0000, 32'h0000_0002, 32'h0000_0000, 1'b0);
    send_fields(32'h0000_0001, 32'h0000_0000, 32'h0000_0003, 32'h0000_0000, 1'b1);
    send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_fields(32'h0000_0010, 32'h0000_0001, 32'h0000_0003, 32'hFFFF_FFFF, 1'b0);
    send_fields(32'hFFFF_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_fields(32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 1'b1);
    drain();
  endtask

  task automatic test_exact_equilibrium;
    set_config(1'b0, 32'h0001_0000, 32'd0, 16'd1);
    send_fields(32'h0001_0000, 32'h0003_0000, 32'h0000_1000, 32'h0003_0000, 1'b1);
    drain();
    set_config(1'b0, 32'h0001_0000, 32'd1, 16'd65535);
    send_fields(32'h0001_0000, 32'h0003_0000, 32'h0000_1000, 32'h0003_0000, 1'b1);
    drain();
  endtask

  task automatic test_three_dimensional;
    set_config(1'b1, 32'd78643, 32'h0010_0000, 16'd3);
    send_fields(32'h0000_0001, 32'h0000_0000, 32'd184467, 32'h0000_0000, 1'b0);
    send_fields(32'h0000_0001, 32'h0000_0000, 32'd184468, 32'h0000_0000, 1'b0);
    send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_fields(32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 32'h0000_8000, 1'b1);
    send_fields(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
    drain();
  endtask

  task automatic test_random_phase(logic d, logic [31:0] e, logic [31:0] t,
                                   logic [15:0] n, int count);
    set_config(d, e, t, n);
    repeat (count) send_particle(random_particle());
    drain();
  endtask

  task automatic test_backpressure;
    set_config(1'b0, 32'd78643, 32'h0001_0000, 16'd4);
    hold_req = 3000;
    repeat (8) send_particle(random_particle());
    drain();
  endtask

  task automatic test_no_idle_stretch;
    calm = 1'b1;
    repeat (60) send_particle(random_particle());
    calm = 1'b0;
    drain();
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    calm = 1'b0;
    hold_req = 0;
    hold_left = 0;
    reset_block();
    test_defaults_directed();
    test_exact_equilibrium();
    test_three_dimensional();
    test_random_phase(1'b0, 32'd78643, 32'd17, 16'd50, 90);
    test_random_phase(1'b1, 32'd78643, 32'h0004_0000, 16'd2, 90);
    test_random_phase(1'b0, 32'd1, 32'hFFFF_FFFF, 16'd65535, 50);
    test_random_phase(1'b1, 32'hFFFF_FFFF, 32'd0, 16'd1, 50);
    test_backpressure();
    test_no_idle_stretch();
    test_random_phase(1'b0, 32'h0001_8000, 32'h0100_0000, 16'd5, 135);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
